// ===== sv/bezier_patch_evaluator_assert.svh =====
// Assertion macros used by the top-level module.
`ifndef BEZIER_PATCH_EVALUATOR_ASSERT_SVH
`define BEZIER_PATCH_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bpe_pkg.sv =====
`default_nettype none
package bpe_pkg;

  // Field widths
  localparam int COORD_W    = 32;
  localparam int PARAM_W    = 17;
  localparam int PIDX_W     = 4;
  localparam int OP_W       = 1;
  localparam int KIND_W     = 2;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Datapath widths: saturated intermediate and raw unit result
  localparam int IW     = 40;
  localparam int RW     = 46;
  localparam int FRAC_W = 16;

  // Parameter defaults
  localparam int MAX_INNER_DEF   = 2;
  localparam int STORE_DEPTH_DEF = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0] OP_EVAL = 1'b1;

  // Patch kinds
  localparam logic [KIND_W-1:0] KIND_CURVE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRI    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUAD   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KIND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

  typedef logic signed [IW-1:0] inter_t;
  typedef logic signed [RW-1:0] raw_t;

  // Clamp a raw unit result to the signed intermediate range
  function automatic inter_t sat_inter(raw_t x);
    if (x[RW-1:IW-1] == {(RW-IW+1){1'b0}} || x[RW-1:IW-1] == {(RW-IW+1){1'b1}}) begin
      return x[IW-1:0];
    end else if (x[RW-1]) begin
      return {1'b1, {(IW-1){1'b0}}};
    end else begin
      return {1'b0, {(IW-1){1'b1}}};
    end
  endfunction

  // Clamp an intermediate to a signed output coordinate
  function automatic logic signed [COORD_W-1:0] sat_out(inter_t x);
    if (x[IW-1:COORD_W-1] == {(IW-COORD_W+1){1'b0}} ||
        x[IW-1:COORD_W-1] == {(IW-COORD_W+1){1'b1}}) begin
      return x[COORD_W-1:0];
    end else if (x[IW-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/bezier_patch_evaluator.sv =====
`default_nettype none
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | operation, point_index, coord_x/y/z, param_u/v
// out     | output    | out_valid / out_ready| out_x, out_y, out_z
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An evaluate first copies the point store into the net entry by entry, then runs each net
// element through the shared interpolator, one coordinate at a time: per element 2, 3
// or 4 operand reads, 1, 2 or 3 interpolations and one write.
// Reset is synchronous active low; the point and net stores are not cleared.
// in_ready is low while an evaluate runs; a finished point waits in the output register.
module bezier_patch_evaluator #(
  parameter int MAX_INNER_POINTS = bpe_pkg::MAX_INNER_DEF,
  parameter int STORE_DEPTH      = bpe_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [bpe_pkg::OP_W-1:0]             in_operation,
  input  wire logic [bpe_pkg::PIDX_W-1:0]           in_point_index,
  input  wire logic signed [bpe_pkg::COORD_W-1:0]   in_coord_x,
  input  wire logic signed [bpe_pkg::COORD_W-1:0]   in_coord_y,
  input  wire logic signed [bpe_pkg::COORD_W-1:0]   in_coord_z,
  input  wire logic [bpe_pkg::PARAM_W-1:0]          in_param_u,
  input  wire logic [bpe_pkg::PARAM_W-1:0]          in_param_v,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [bpe_pkg::COORD_W-1:0]        out_x,
  output logic signed [bpe_pkg::COORD_W-1:0]        out_y,
  output logic signed [bpe_pkg::COORD_W-1:0]        out_z,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [bpe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [bpe_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import bpe_pkg::*;

`include "bezier_patch_evaluator_assert.svh"

  localparam int NET_ROW   = MAX_INNER_POINTS + 2;
  localparam int NET_DEPTH = NET_ROW * NET_ROW;
  localparam int NW        = $clog2(NET_DEPTH);
  localparam int SW        = $clog2(STORE_DEPTH);
  localparam int CW        = $clog2(NET_ROW);
  localparam int CPW       = $clog2(((NET_DEPTH > STORE_DEPTH) ? NET_DEPTH : STORE_DEPTH) + 1);
  localparam logic [1:0] LAST_COORD = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CP_RD, S_CP_WR, S_RD_ADDR, S_RD_CAP, S_OP_ISS, S_OP_WB, S_WR, S_FIN
  } state_t;

  state_t               state_r;
  logic [KIND_W-1:0]    cfg_kind_r;
  logic [COUNT_W-1:0]   cfg_count_r;
  logic [PARAM_W-1:0]   u_r, v_r;
  logic [CW-1:0]        n_r, i_r, j_r, n_start;
  logic [NW-1:0]        a_r, c_r, dst_r;
  logic [CPW-1:0]       cp_r;
  logic                 cp_in_r;
  logic [1:0]           rk_r, op_r, co_r, rk_last, op_last;
  inter_t               opnd_r [4][3];
  raw_t                 t0_r [3];
  inter_t               t1_r [3];
  inter_t               res_r [3];
  logic                 out_valid_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r, out_z_r;
  logic                 row_end;

  // Stores
  logic [3*COORD_W-1:0] store_mem [STORE_DEPTH];
  logic [3*COORD_W-1:0] store_q_r;
  logic [3*IW-1:0]      scr_mem [NET_DEPTH];
  logic [3*IW-1:0]      scr_q_r, scr_wdata;
  logic [NW-1:0]        scr_raddr, scr_waddr;
  logic                 scr_we, load_we, in_acc;

  // Shared interpolator
  inter_t               unit_a, unit_b;
  logic [PARAM_W-1:0]   unit_t;
  raw_t                 unit_base, unit_raw;
  inter_t               unit_sat;

  bpe_unit u_unit (
    .clk    (clk),
    .a_i    (unit_a),
    .b_i    (unit_b),
    .t_i    (unit_t),
    .base_i (unit_base),
    .raw_o  (unit_raw)
  );

  assign unit_sat  = sat_inter(unit_raw);
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign cfg_ready = in_ready;
  assign in_acc    = in_valid && in_ready;
  assign load_we   = in_acc && (in_operation == OP_LOAD) &&
                     (32'(in_point_index) < STORE_DEPTH);
  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

  // Clamp the inner count, pick read and op counts per kind
  always_comb begin
    n_start = (cfg_count_r > COUNT_W'(MAX_INNER_POINTS)) ? CW'(MAX_INNER_POINTS)
                                                          : CW'(cfg_count_r);
    rk_last = 2'd3;
    op_last = 2'd2;
    row_end = (i_r == n_r);
    unique case (cfg_kind_r)
      KIND_CURVE: begin
        rk_last = 2'd1;
        op_last = 2'd0;
      end
      KIND_TRI: begin
        rk_last = 2'd2;
        op_last = 2'd1;
        row_end = (i_r == n_r - j_r);
      end
      default: begin
      end
    endcase
  end

  // Net read address per operand slot
  always_comb begin
    unique case (rk_r)
      2'd0:    scr_raddr = a_r;
      2'd1:    scr_raddr = a_r + NW'(1);
      2'd2:    scr_raddr = c_r;
      default: scr_raddr = c_r + NW'(1);
    endcase
  end

  // Net write port: copy pass or reduced element
  always_comb begin
    scr_we    = 1'b0;
    scr_waddr = dst_r;
    scr_wdata = {res_r[2], res_r[1], res_r[0]};
    if (state_r == S_CP_WR) begin
      scr_we    = 1'b1;
      scr_waddr = cp_r[NW-1:0];
      scr_wdata = '0;
      if (cp_in_r) begin
        for (int k = 0; k < 3; k++) begin
          scr_wdata[k*IW +: IW] = IW'($signed(store_q_r[k*COORD_W +: COORD_W]));
        end
      end
    end else if (state_r == S_WR) begin
      scr_we = 1'b1;
    end
  end

  // Select interpolator operands
  always_comb begin
    unit_a    = opnd_r[0][co_r];
    unit_b    = opnd_r[1][co_r];
    unit_t    = u_r;
    unit_base = RW'(opnd_r[0][co_r]);
    case (cfg_kind_r)
      KIND_TRI: begin
        if (op_r != 2'd0) begin
          unit_b    = opnd_r[2][co_r];
          unit_t    = v_r;
          unit_base = t0_r[co_r];
        end
      end
      KIND_QUAD: begin
        case (op_r)
          2'd0: begin
            unit_b = opnd_r[2][co_r];
            unit_t = v_r;
          end
          2'd1: begin
            unit_a    = opnd_r[1][co_r];
            unit_b    = opnd_r[3][co_r];
            unit_t    = v_r;
            unit_base = RW'(opnd_r[1][co_r]);
          end
          default: begin
            unit_a    = t0_r[co_r][IW-1:0];
            unit_b    = t1_r[co_r];
            unit_base = t0_r[co_r];
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Store and net memories
  always_ff @(posedge clk) begin
    if (load_we) begin
      store_mem[SW'(in_point_index)] <= {in_coord_z, in_coord_y, in_coord_x};
    end
    store_q_r <= store_mem[cp_r[SW-1:0]];
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    scr_q_r <= scr_mem[scr_raddr];
  end

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_kind_r  <= KIND_QUAD;
      cfg_count_r <= COUNT_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_KIND:  cfg_kind_r  <= cfg_data[KIND_W-1:0];
          CFG_COUNT: cfg_count_r <= cfg_data[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
      // drop the result once taken
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_operation == OP_EVAL) begin
            u_r <= in_param_u;
            v_r <= in_param_v;
            cp_r <= '0;
            if (cfg_kind_r == KIND_UNUSED) begin
              for (int k = 0; k < 3; k++) res_r[k] <= '0;
              state_r <= S_FIN;
            end else begin
              state_r <= S_CP_RD;
            end
          end
        end
        S_CP_RD: begin
          cp_in_r <= (32'(cp_r) < STORE_DEPTH);
          state_r <= S_CP_WR;
        end
        S_CP_WR: begin
          cp_r <= cp_r + CPW'(1);
          if (cp_r == CPW'(NET_DEPTH - 1)) begin
            n_r     <= n_start;
            i_r     <= '0;
            j_r     <= '0;
            a_r     <= '0;
            c_r     <= NW'(n_start) + NW'(2);
            dst_r   <= '0;
            rk_r    <= '0;
            state_r <= S_RD_ADDR;
          end else begin
            state_r <= S_CP_RD;
          end
        end
        S_RD_ADDR: begin
          state_r <= S_RD_CAP;
        end
        S_RD_CAP: begin
          for (int k = 0; k < 3; k++) begin
            opnd_r[rk_r][k] <= scr_q_r[k*IW +: IW];
          end
          if (rk_r == rk_last) begin
            op_r    <= '0;
            co_r    <= '0;
            state_r <= S_OP_ISS;
          end else begin
            rk_r    <= rk_r + 2'd1;
            state_r <= S_RD_ADDR;
          end
        end
        S_OP_ISS: begin
          state_r <= S_OP_WB;
        end
        S_OP_WB: begin
          case (cfg_kind_r)
            KIND_TRI: begin
              if (op_r == 2'd0) t0_r[co_r] <= unit_raw;
              else              res_r[co_r] <= unit_sat;
            end
            KIND_QUAD: begin
              case (op_r)
                2'd0:    t0_r[co_r]  <= RW'(unit_sat);
                2'd1:    t1_r[co_r]  <= unit_sat;
                default: res_r[co_r] <= unit_sat;
              endcase
            end
            default: res_r[co_r] <= unit_sat;
          endcase
          if (co_r == LAST_COORD) begin
            co_r <= '0;
            if (op_r == op_last) begin
              state_r <= S_WR;
            end else begin
              op_r    <= op_r + 2'd1;
              state_r <= S_OP_ISS;
            end
          end else begin
            co_r    <= co_r + 2'd1;
            state_r <= S_OP_ISS;
          end
        end
        S_WR: begin
          dst_r <= dst_r + NW'(1);
          rk_r  <= '0;
          if (!row_end) begin
            i_r     <= i_r + CW'(1);
            a_r     <= a_r + NW'(1);
            c_r     <= c_r + NW'(1);
            state_r <= S_RD_ADDR;
          end else if (cfg_kind_r == KIND_CURVE || j_r == n_r) begin
            // level done
            if (n_r == '0) begin
              state_r <= S_FIN;
            end else begin
              n_r     <= n_r - CW'(1);
              i_r     <= '0;
              j_r     <= '0;
              a_r     <= '0;
              c_r     <= NW'(n_r) + NW'(1);
              dst_r   <= '0;
              state_r <= S_RD_ADDR;
            end
          end else begin
            // advance to next row
            j_r     <= j_r + CW'(1);
            i_r     <= '0;
            a_r     <= a_r + NW'(2);
            c_r     <= (cfg_kind_r == KIND_QUAD) ? c_r + NW'(2) : c_r + NW'(1);
            state_r <= S_RD_ADDR;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_x_r     <= sat_out(res_r[0]);
            out_y_r     <= sat_out(res_r[1]);
            out_z_r     <= sat_out(res_r[2]);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BPE_ASSERT_NEXT(a_eval_start,
    in_acc && in_operation == OP_EVAL && cfg_kind_r != KIND_UNUSED,
    state_r == S_CP_RD, "evaluate did not start the copy pass")
  `BPE_ASSERT_NOW(a_in_place, state_r == S_WR, dst_r <= a_r,
    "reduced element would overwrite an unread net entry")
  `BPE_ASSERT_NEXT(a_out_load, state_r == S_FIN && !out_valid_r,
    out_valid_r && state_r == S_IDLE, "finished point not moved to output")

endmodule
`default_nettype wire

// ===== sv/bpe_unit.sv =====
`default_nettype none
module bpe_unit (
  input  wire logic                       clk,
  input  wire bpe_pkg::inter_t            a_i,
  input  wire bpe_pkg::inter_t            b_i,
  input  wire logic [bpe_pkg::PARAM_W-1:0] t_i,
  input  wire bpe_pkg::raw_t              base_i,
  output bpe_pkg::raw_t                   raw_o
);
  import bpe_pkg::*;

  localparam int DW = IW + 1;
  localparam int PW = DW + PARAM_W + 1;

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod_r;
  raw_t                 base_r;

  // Difference of the two operands
  assign diff = DW'(b_i) - DW'(a_i);

  // Register the product and the addend
  always_ff @(posedge clk) begin
    prod_r <= PW'(diff) * PW'($signed({1'b0, t_i}));
    base_r <= base_i;
  end

  // Floor shift and add back the base
  assign raw_o = RW'(prod_r >>> FRAC_W) + base_r;

endmodule
`default_nettype wire

// ===== test/bezier_patch_evaluator_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module bezier_patch_evaluator_tb;
  import bpe_pkg::*;

  localparam int NET_ROW    = MAX_INNER_DEF + 2;
  localparam int NET_SIZE   = NET_ROW * NET_ROW;
  localparam int STALL_MAX  = 20000;
  localparam int SETTLE     = 20;
  localparam longint I_MAX  = 64'sd549755813887;
  localparam longint I_MIN  = -64'sd549755813888;
  localparam longint C_MAX  = 64'sd2147483647;
  localparam longint C_MIN  = -64'sd2147483648;

  typedef struct {
    longint c[3];
  } pt_t;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [PIDX_W-1:0]        idx;
    logic signed [31:0]       x, y, z;
    logic [PARAM_W-1:0]       u, v;
    logic [KIND_W-1:0]        kind;
    logic [COUNT_W-1:0]       count;
    bit                       typed;
    logic signed [31:0]       ex, ey, ez;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_operation = OP_LOAD;
  logic [PIDX_W-1:0] in_point_index = '0;
  logic signed [COORD_W-1:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic [PARAM_W-1:0] in_param_u = '0, in_param_v = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_x, out_y, out_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bezier_patch_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_point_index(in_point_index),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_param_u(in_param_u), .in_param_v(in_param_v),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Predictor state
  pt_t ctrl_pts[STORE_DEPTH_DEF];
  pt_t work_net[NET_SIZE];
  logic [KIND_W-1:0] cur_kind = KIND_QUAD;
  logic [COUNT_W-1:0] cur_count = 4'd2;

  logic signed [31:0] pending_pts[$][3];
  int errors = 0;
  int n_loads = 0, n_evals = 0, n_checked = 0, n_cfg = 0;
  int send_idle = 0, recv_idle = 0, hold_left = 0;

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // Floor of d*t/2^16
  function automatic longint scale(longint d, longint t);
    return (d * t) >>> 16;
  endfunction

  function automatic pt_t blend(pt_t a, pt_t b, longint t);
    pt_t r;
    for (int k = 0; k < 3; k++) begin
      r.c[k] = clamp(scale(b.c[k] - a.c[k], t) + a.c[k], I_MIN, I_MAX);
    end
    return r;
  endfunction

  function automatic pt_t tri_step(pt_t a, pt_t bu, pt_t bv, longint u, longint v);
    pt_t r;
    for (int k = 0; k < 3; k++) begin
      r.c[k] = clamp(scale(bu.c[k] - a.c[k], u) + scale(bv.c[k] - a.c[k], v) + a.c[k],
                     I_MIN, I_MAX);
    end
    return r;
  endfunction

  // Reduce the control net to a single point for the current patch kind
  function automatic pt_t eval_patch(longint u, longint v);
    pt_t r;
    int n, row, dst, a, c;
    r.c = '{0, 0, 0};
    if (cur_kind == KIND_UNUSED) return r;
    n = (cur_count > MAX_INNER_DEF) ? MAX_INNER_DEF : cur_count;
    for (int i = 0; i < NET_SIZE; i++) begin
      work_net[i] = ctrl_pts[i];
    end
    for (int lvl = n; lvl >= 0; lvl--) begin
      row = lvl + 2;
      dst = 0;
      a = 0;
      c = row;
      if (cur_kind == KIND_CURVE) begin
        for (int i = 0; i <= lvl; i++) begin
          work_net[i] = blend(work_net[i], work_net[i+1], u);
        end
      end else if (cur_kind == KIND_TRI) begin
        // the v neighbor advances only inside a row
        for (int j = 0; j <= lvl; j++) begin
          for (int i = 0; i <= lvl - j; i++) begin
            work_net[dst] = tri_step(work_net[a], work_net[a+1], work_net[c], u, v);
            dst++;
            a++;
            c++;
          end
          a++;
        end
      end else begin
        for (int j = 0; j <= lvl; j++) begin
          for (int i = 0; i <= lvl; i++) begin
            work_net[dst] = blend(blend(work_net[a], work_net[a+row], v),
                                  blend(work_net[a+1], work_net[a+row+1], v), u);
            dst++;
            a++;
          end
          a++;
        end
      end
    end
    return work_net[0];
  endfunction

  task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (eval %0d)", what, got, want, n_checked);
  endtask

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Check each result transaction against the oldest expected point
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pts.size() == 0) begin
        report("unexpected result x", out_x, 0);
      end else begin
        if (out_x !== pending_pts[0][0]) report("out_x", out_x, pending_pts[0][0]);
        if (out_y !== pending_pts[0][1]) report("out_y", out_y, pending_pts[0][1]);
        if (out_z !== pending_pts[0][2]) report("out_z", out_z, pending_pts[0][2]);
        void'(pending_pts.pop_front());
        n_checked++;
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_MAX) begin
      $display("watchdog: no progress for %0d cycles", STALL_MAX);
      $display("bezier_patch_evaluator_tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Wait for every expected point, then let trailing loads settle
  task automatic drain();
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == CFG_KIND) cur_kind = val[KIND_W-1:0];
    else if (idx == CFG_COUNT) cur_count = val;
    n_cfg++;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [KIND_W-1:0] kind, logic [COUNT_W-1:0] count);
    drain();
    write_reg(CFG_KIND, CFG_DATA_W'(kind));
    @(posedge clk);
    write_reg(CFG_COUNT, count);
    @(posedge clk);
  endtask

  // Offer one transaction, hold it until accepted, then update the predictor
  task automatic send(row_t r);
    pt_t p;
    logic signed [31:0] want[3];
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid       <= 1'b1;
    in_operation   <= r.op;
    in_point_index <= r.idx;
    in_coord_x     <= r.x;
    in_coord_y     <= r.y;
    in_coord_z     <= r.z;
    in_param_u     <= r.u;
    in_param_v     <= r.v;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (r.op == OP_LOAD) begin
      ctrl_pts[r.idx].c = '{longint'(r.x), longint'(r.y), longint'(r.z)};
      n_loads++;
    end else begin
      if (r.typed) begin
        want = '{r.ex, r.ey, r.ez};
      end else begin
        p = eval_patch(longint'(r.u), longint'(r.v));
        for (int k = 0; k < 3; k++) want[k] = 32'(clamp(p.c[k], C_MIN, C_MAX));
      end
      pending_pts.push_back(want);
      n_evals++;
    end
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      1: return $urandom;
      2: begin
        case ($urandom_range(3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          default: return 32'hffffffff;
        endcase
      end
      default: return $signed($urandom_range(0, 1 << 28)) - (1 << 27);
    endcase
  endfunction

  function automatic logic [PARAM_W-1:0] rand_param();
    case ($urandom_range(7))
      0: return 17'd0;
      1: return 17'd65536;
      2: return PARAM_W'($urandom_range(65537, 131071));
      default: return PARAM_W'($urandom_range(0, 65536));
    endcase
  endfunction

  row_t dir_rows[$];
  row_t item;
  logic [KIND_W-1:0] ph_kind[10] = '{KIND_QUAD, KIND_CURVE, KIND_TRI, KIND_QUAD, KIND_CURVE,
                                     KIND_UNUSED, KIND_TRI, KIND_QUAD, KIND_CURVE, KIND_TRI};
  logic [COUNT_W-1:0] ph_count[10] = '{4'd0, 4'd2, 4'd1, 4'd1, 4'd15,
                                       4'd3, 4'd0, 4'd2, 4'd1, 4'd14};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill the store with one extreme point so every used kind returns it and the unused kind returns zero
    for (int i = 0; i < STORE_DEPTH_DEF; i++) begin
      dir_rows.push_back('{OP_LOAD, PIDX_W'(i), 32'h7fffffff, 32'h80000000, 32'h00010000,
                           17'd0, 17'd0, KIND_QUAD, 4'd2, 1'b0, 0, 0, 0});
    end
    dir_rows.push_back('{OP_EVAL, 0, 0, 0, 0, 17'd0, 17'd65536, KIND_QUAD, 4'd2,
                         1'b1, 32'h7fffffff, 32'h80000000, 32'h00010000});
    dir_rows.push_back('{OP_EVAL, 0, 0, 0, 0, 17'd65536, 17'd0, KIND_CURVE, 4'd0,
                         1'b1, 32'h7fffffff, 32'h80000000, 32'h00010000});
    dir_rows.push_back('{OP_EVAL, 0, 0, 0, 0, 17'd30000, 17'd40000, KIND_TRI, 4'd14,
                         1'b1, 32'h7fffffff, 32'h80000000, 32'h00010000});
    dir_rows.push_back('{OP_EVAL, 0, 0, 0, 0, 17'd131071, 17'd131071, KIND_UNUSED, 4'd14,
                         1'b1, 0, 0, 0});
    // Mixed extremes, then extrapolation beyond one
    dir_rows.push_back('{OP_LOAD, 15, 32'h80000000, 32'h7fffffff, 32'h0,
                         17'd0, 17'd0, KIND_QUAD, 4'd1, 1'b0, 0, 0, 0});
    dir_rows.push_back('{OP_LOAD, 0, 32'h7fffffff, 32'hffffffff, 32'h80000000,
                         17'd0, 17'd0, KIND_QUAD, 4'd1, 1'b0, 0, 0, 0});
    dir_rows.push_back('{OP_LOAD, 5, 32'h00018000, 32'hfffe8000, 32'h12345678,
                         17'd0, 17'd0, KIND_QUAD, 4'd1, 1'b0, 0, 0, 0});
    dir_rows.push_back('{OP_EVAL, 0, 0, 0, 0, 17'd65536, 17'd65536, KIND_QUAD, 4'd1,
                         1'b0, 0, 0, 0});
    dir_rows.push_back('{OP_EVAL, 0, 0, 0, 0, 17'd131071, 17'd65536, KIND_TRI, 4'd2,
                         1'b0, 0, 0, 0});
    dir_rows.push_back('{OP_EVAL, 0, 0, 0, 0, 17'd0, 17'd1, KIND_CURVE, 4'd2,
                         1'b0, 0, 0, 0});

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == OP_EVAL &&
          (dir_rows[i].kind != cur_kind || dir_rows[i].count != cur_count)) begin
        in_valid <= 1'b0;
        set_config(dir_rows[i].kind, dir_rows[i].count);
      end
      send(dir_rows[i]);
    end

    // Random phases: each with its own setting; the idle pattern changes between groups of phases
    for (int ph = 0; ph < 10; ph++) begin
      in_valid <= 1'b0;
      set_config(ph_kind[ph], ph_count[ph]);
      if (ph < 4) begin
        send_idle = 10;
        recv_idle = 87;
      end else if (ph < 7) begin
        send_idle = 87;
        recv_idle = 10;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      // Hold the receiver off so results back up and stall the input
      if (ph == 1) hold_left = 400;
      for (int n = 0; n < 100; n++) begin
        item.op    = ($urandom_range(99) < 30) ? OP_EVAL : OP_LOAD;
        item.idx   = PIDX_W'($urandom_range(0, 15));
        item.x     = rand_coord();
        item.y     = rand_coord();
        item.z     = rand_coord();
        item.u     = rand_param();
        item.v     = rand_param();
        item.typed = 1'b0;
        send(item);
      end
    end

    in_valid <= 1'b0;
    drain();
    $display("covered %0d loads, %0d evaluations (%0d checked), %0d register writes",
             n_loads, n_evals, n_checked, n_cfg);
    $display("all patch kinds, counts from zero past the clamp, u/v extremes and extrapolation");
    if (errors == 0) begin
      $display("bezier_patch_evaluator_tb: PASS");
    end else begin
      $display("bezier_patch_evaluator_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/bpe_pkg.sv
sv/bpe_unit.sv
sv/bezier_patch_evaluator.sv
test/bezier_patch_evaluator_tb.sv
